### design/ps2_mouse_packet_cursor_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// PS/2 cursor tracker assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define PMPCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pmpct_pkg.sv
// ----------------------------------------------------------------------------
// pmpct_pkg
// Types, constants and helpers for the PS/2 packet cursor tracker.
// ----------------------------------------------------------------------------
package pmpct_pkg;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_MAX = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_MAX    = 4'd1;

    localparam logic [7:0] COLUMN_MAX_RESET = 8'd79;
    localparam logic [7:0] ROW_MAX_RESET    = 8'd24;
    localparam logic [7:0] COLUMN_RESET     = 8'd40;
    localparam logic [7:0] ROW_RESET        = 8'd12;

    // header bits
    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } pos_t;

    // signed quotient of 9-bit movement by 8, toward zero
    function automatic logic signed [5:0] div8_trunc(input logic signed [8:0] v);
        logic signed [8:0] adj;
        logic signed [8:0] q;
        adj = v + (v[8] ? 9'sd7 : 9'sd0);
        q   = adj >>> 3;
        return q[5:0];
    endfunction

    // signed quotient of 9-bit movement by 16, toward zero
    function automatic logic signed [4:0] div16_trunc(input logic signed [8:0] v);
        logic signed [8:0] adj;
        logic signed [8:0] q;
        adj = v + (v[8] ? 9'sd15 : 9'sd0);
        q   = adj >>> 4;
        return q[4:0];
    endfunction

    function automatic logic [7:0] move_clamped(
        input logic [7:0]        pos,
        input logic signed [5:0] delta,
        input logic [7:0]        limit
    );
        logic signed [9:0] sum;
        sum = $signed({2'b00, pos}) + 10'(delta);
        if (sum < 10'sd0) begin
            return 8'd0;
        end
        if (sum > $signed({2'b00, limit})) begin
            return limit;
        end
        return sum[7:0];
    endfunction

endpackage

### design/ps2_mouse_packet_cursor_tracker_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// Decodes three-byte PS/2 mouse packets and tracks a text-cell cursor.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes the input register, then the result register.
// Throughput: one word per cycle while out_ready holds; input register feeds one
// short decode/clamp step into the result register, which frees as it is taken.
// Reset: async active low; cursor at column 40 row 12, limits 79/24,
// buttons clear, packet position back to header, pipeline empty.
`include "ps2_mouse_packet_cursor_tracker_core_assert.svh"

module ps2_mouse_packet_cursor_tracker_core
    import pmpct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             cursor_column,
    output logic [7:0]             cursor_row,
    output logic [2:0]             button_bits,
    output logic                   packet_done,
    output logic                   byte_dropped,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_column_reg;
    logic [7:0] out_row_reg;
    logic [2:0] out_buttons_reg;
    logic       out_done_reg;
    logic       out_dropped_reg;

    logic [7:0] column_max_reg;
    logic [7:0] row_max_reg;
    pos_t       pos_reg;
    pos_t       pos_next;
    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic [7:0] x_move_reg;
    logic [7:0] x_move_next;
    logic [7:0] column_reg;
    logic [7:0] column_next;
    logic [7:0] row_reg;
    logic [7:0] row_next;
    logic [2:0] buttons_reg;
    logic [2:0] buttons_next;
    logic       done_next;
    logic       dropped_next;

    logic       advance;
    logic       s1_fire;
    logic       in_fire;

    logic signed [8:0] dx;
    logic signed [8:0] dy_raw;
    logic signed [5:0] step_x;
    logic signed [5:0] step_y;

    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            column_max_reg <= COLUMN_MAX_RESET;
            row_max_reg    <= ROW_MAX_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                CFG_COLUMN_MAX: column_max_reg <= cfg_data;
                CFG_ROW_MAX:    row_max_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            s1_byte_reg <= rx_byte;
        end
    end

    // packet position sequencing
    always_comb begin
        pos_next = pos_reg;
        unique case (pos_reg)
            POS_HEADER:
            begin
                if (s1_byte_reg[HDR_SYNC_BIT]) begin
                    pos_next = POS_X;
                end
            end
            POS_X:   pos_next = POS_Y;
            default: pos_next = POS_HEADER;
        endcase
    end

    // movement arithmetic
    always_comb begin
        dx     = $signed({header_reg[HDR_XSIGN_BIT], x_move_reg});
        dy_raw = $signed({header_reg[HDR_YSIGN_BIT], s1_byte_reg});
        step_x = div8_trunc(dx);
        // rows grow downward
        step_y = -6'(div16_trunc(dy_raw));
    end

    // per-word datapath and flags
    always_comb begin
        header_next  = header_reg;
        x_move_next  = x_move_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        buttons_next = buttons_reg;
        done_next    = 1'b0;
        dropped_next = 1'b0;
        unique case (pos_reg)
            POS_HEADER:
            begin
                if (s1_byte_reg[HDR_SYNC_BIT]) begin
                    header_next = s1_byte_reg;
                end
                else begin
                    dropped_next = 1'b1;
                end
            end
            POS_X:
            begin
                x_move_next = s1_byte_reg;
            end
            default:
            begin
                buttons_next = header_reg[2:0];
                column_next  = move_clamped(column_reg, step_x, column_max_reg);
                row_next     = move_clamped(row_reg, step_y, row_max_reg);
                done_next    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg     <= POS_HEADER;
            header_reg  <= 8'd0;
            x_move_reg  <= 8'd0;
            column_reg  <= COLUMN_RESET;
            row_reg     <= ROW_RESET;
            buttons_reg <= 3'd0;
        end
        else if (s1_fire) begin
            pos_reg     <= pos_next;
            header_reg  <= header_next;
            x_move_reg  <= x_move_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
            buttons_reg <= buttons_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_fire) begin
            out_column_reg  <= column_next;
            out_row_reg     <= row_next;
            out_buttons_reg <= buttons_next;
            out_done_reg    <= done_next;
            out_dropped_reg <= dropped_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_column = out_column_reg;
    assign cursor_row    = out_row_reg;
    assign button_bits   = out_buttons_reg;
    assign packet_done   = out_done_reg;
    assign byte_dropped  = out_dropped_reg;

    // a word in the input stage always moves on when the result register is empty
    `PMPCT_ASSERT_NEXT(a_fill_result, s1_valid_reg && !out_valid_reg, out_valid_reg,
        "input stage word did not reach result register")

    // third byte of a packet reports completion
    `PMPCT_ASSERT_NEXT(a_third_done, s1_fire && pos_reg == POS_Y,
        out_done_reg && !out_dropped_reg && pos_reg == POS_HEADER,
        "third byte did not complete packet")

    // dropped header byte leaves the cursor untouched
    `PMPCT_ASSERT_NEXT(a_drop_holds, s1_fire && pos_reg == POS_HEADER && !s1_byte_reg[HDR_SYNC_BIT],
        out_dropped_reg && column_reg == $past(column_reg) && row_reg == $past(row_reg),
        "dropped byte changed cursor state")

endmodule

### sim/tb_ps2_mouse_packet_cursor_tracker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_cursor_tracker_core
// Streams PS/2 mouse bytes into the cursor tracker and checks every result
// word against a cycle-free tracker model kept in the bench. Directed packets
// hit the sign, truncation and clamp corners; random traffic with random
// gaps, receiver stalls and a long receiver hold covers the rest, across
// several column/row limit settings.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_cursor_tracker_core;
    import pmpct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 60;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_TOP = '1;

    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
        logic [2:0] buttons;
        logic       done;
        logic       dropped;
    } cursor_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             cursor_column;
    logic [7:0]             cursor_row;
    logic [2:0]             button_bits;
    logic                   packet_done;
    logic                   byte_dropped;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = '0;

    // tracker model state
    pos_t       trk_pos;
    logic [7:0] trk_header;
    logic [7:0] trk_xbyte;
    logic [7:0] trk_column;
    logic [7:0] trk_row;
    logic [2:0] trk_buttons;
    logic [7:0] column_limit;
    logic [7:0] row_limit;

    logic [7:0]     mouse_bytes[$];
    cursor_report_t cursor_reports_due[$];

    int  n_queued = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    int  rx_hold = 0;
    bit  no_idle = 1'b0;

    ps2_mouse_packet_cursor_tracker_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .button_bits   (button_bits),
        .packet_done   (packet_done),
        .byte_dropped  (byte_dropped),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] clamp_cell(input logic [7:0] pos, input int delta,
                                              input logic [7:0] limit);
        int sum;
        sum = int'(pos) + delta;
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > int'(limit))
        begin
            sum = int'(limit);
        end
        return sum[7:0];
    endfunction

    // advance the tracker model by one mouse byte
    function automatic cursor_report_t track_byte(input logic [7:0] b);
        int             dx;
        int             dy;
        cursor_report_t r;
        r.done    = 1'b0;
        r.dropped = 1'b0;
        case (trk_pos)
            POS_HEADER:
            begin
                if (!b[HDR_SYNC_BIT])
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    trk_header = b;
                    trk_pos    = POS_X;
                end
            end
            POS_X:
            begin
                trk_xbyte = b;
                trk_pos   = POS_Y;
            end
            default:
            begin
                dx = int'(trk_xbyte) - (trk_header[HDR_XSIGN_BIT] ? 256 : 0);
                dy = -(int'(b) - (trk_header[HDR_YSIGN_BIT] ? 256 : 0));
                trk_buttons = trk_header[2:0];
                // int division truncates toward zero
                trk_column  = clamp_cell(trk_column, dx / 8, column_limit);
                trk_row     = clamp_cell(trk_row, dy / 16, row_limit);
                trk_pos     = POS_HEADER;
                r.done      = 1'b1;
            end
        endcase
        r.column  = trk_column;
        r.row     = trk_row;
        r.buttons = trk_buttons;
        return r;
    endfunction

    task automatic flag_error(input string what, input cursor_report_t want,
                              input cursor_report_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t %s: exp col %0d row %0d btn %0d done %0b drop %0b",
                     $time, what, want.column, want.row, want.buttons, want.done,
                     want.dropped);
            $display("%0t %s: got col %0d row %0d btn %0d done %0b drop %0b",
                     $time, what, got.column, got.row, got.buttons, got.done,
                     got.dropped);
        end
    endtask

    task automatic send(input logic [7:0] b);
        mouse_bytes.push_back(b);
        n_queued++;
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x,
                               input logic [7:0] y);
        send(hdr);
        send(x);
        send(y);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_COLUMN_MAX)
        begin
            column_limit = data;
        end
        else if (idx == CFG_ROW_MAX)
        begin
            row_limit = data;
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (n_in != n_queued || n_out != n_in);
    endtask

    // mostly well-formed packets, some lone noise bytes and misaligning strays
    task automatic queue_random_traffic(input int n_items);
        int         sent;
        logic [7:0] b;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    b    = 8'($urandom_range(0, 255));
                    b[3] = 1'b0;
                    send(b);
                end
                1:
                begin
                    send(8'($urandom_range(0, 255)));
                    sent++;
                end
                default:
                begin
                    hdr    = 8'($urandom_range(0, 255));
                    hdr[3] = 1'b1;
                    send_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    sent += 3;
                end
            endcase
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
            tx_gap   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cursor_reports_due.push_back(track_byte(rx_byte));
                n_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (mouse_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= mouse_bytes.pop_front();
                    if (!no_idle && $urandom_range(0, 2) == 0)
                    begin
                        tx_gap = pick_gap();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t got;
        cursor_report_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  = 0;
            rx_hold   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {cursor_column, cursor_row, button_bits, packet_done, byte_dropped};
                if (cursor_reports_due.size() == 0)
                begin
                    flag_error("unexpected word", '0, got);
                end
                else
                begin
                    want = cursor_reports_due.pop_front();
                    if (got !== want)
                    begin
                        flag_error("mismatch", want, got);
                    end
                end
                n_out++;
                // long hold-off so the block backs up and stalls its input
                if (n_out == 60 || n_out == 300)
                begin
                    rx_hold = LONG_HOLD;
                end
            end
            if (rx_hold != 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_stall != 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                begin
                    rx_stall = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] col_set;
        logic [7:0] row_set;
        trk_pos      = POS_HEADER;
        trk_header   = '0;
        trk_xbyte    = '0;
        trk_column   = COLUMN_RESET;
        trk_row      = ROW_RESET;
        trk_buttons  = '0;
        column_limit = COLUMN_MAX_RESET;
        row_limit    = ROW_MAX_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: drops, sign corners, truncation toward zero
        send(8'h00);
        send(8'hF7);
        send_packet(8'h0F, 8'hFF, 8'hFF);
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'h18, 8'h01, 8'h0F);
        send_packet(8'h28, 8'h07, 8'hF1);
        send_packet(8'h2B, 8'h08, 8'hF0);
        send_packet(8'hFF, 8'h80, 8'h80);
        wait_idle();

        // new limits below the current position take hold only on packet end
        write_reg(CFG_UNUSED_TOP, 8'h00);
        write_reg(CFG_COLUMN_MAX, 8'd5);
        write_reg(CFG_ROW_MAX, 8'd3);
        send_packet(8'h08, 8'h00, 8'h00);
        wait_idle();
        write_reg(CFG_COLUMN_MAX, 8'd0);
        wait_idle();
        write_reg(CFG_ROW_MAX, 8'd0);
        send_packet(8'h0D, 8'h7F, 8'h81);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       begin col_set = 8'd255; row_set = 8'd255; end
                1:       begin col_set = 8'd0;   row_set = 8'd0;   end
                2:       begin col_set = 8'd1;   row_set = 8'd1;   end
                3:       begin col_set = COLUMN_MAX_RESET; row_set = ROW_MAX_RESET; end
                6:       begin col_set = 8'd255; row_set = 8'd1;   end
                default:
                begin
                    col_set = 8'($urandom_range(0, 255));
                    row_set = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_COLUMN_MAX, col_set);
            write_reg(CFG_ROW_MAX, row_set);
            no_idle = (p == 4);
            queue_random_traffic(PHASE_ITEMS);
            // sender pauses here until every word of the phase is back
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (cursor_reports_due.size() != 0)
        begin
            errors++;
            $display("%0d expected words never arrived", cursor_reports_due.size());
        end
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/pmpct_pkg.sv
design/ps2_mouse_packet_cursor_tracker_core.sv
sim/tb_ps2_mouse_packet_cursor_tracker_core.sv
